// ----- rtl/rs_enc_pkg.sv -----
// rs_enc_pkg: types, constants and field functions for the rs(255,k) encoder
// gf(2^8) over 0x11d; no dependencies
package rs_enc_pkg;

  localparam int MAX_PAR = 32;
  localparam int CODE_LEN = 255;
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  typedef logic [7:0] sym_t;
  typedef logic [MAX_PAR:0][7:0] genpoly_t;

  function automatic sym_t gf_mul(input sym_t a, input sym_t b);
    logic [8:0] x;
    sym_t r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ FIELD_POLY;
      end
    end
    return r;
  endfunction

  // g(x) = (x + a^1)(x + a^2)...(x + a^npar), coefficient i at index i
  function automatic genpoly_t gen_poly(input int npar);
    genpoly_t g;
    sym_t root;
    g = '0;
    g[0] = 8'd1;
    root = 8'd1;
    for (int i = 0; i < MAX_PAR; i++) begin
      if (i < npar) begin
        root = gf_mul(root, 8'd2);
        g[i + 1] = g[i];
        for (int j = MAX_PAR - 1; j > 0; j--) begin
          if (j <= i) begin
            g[j] = g[j - 1] ^ gf_mul(g[j], root);
          end
        end
        g[0] = gf_mul(g[0], root);
      end
    end
    return g;
  endfunction

endpackage

// ----- rtl/reed_solomon_255_247_encoder_core.sv -----
// reed_solomon_255_247_encoder_core: systematic rs encoder, parity lfsr and parity output buffer
// depends on rs_enc_pkg
//
//  channel | direction | ports                                          | word
//  in      | sink      | in_valid in_stall in_data_byte in_last_byte    | one message byte
//  out     | source    | out_valid out_stall out_parity_byte            | one parity symbol
//          |           | out_parity_position out_status out_last_result |
//
// a message byte is taken every cycle, but a last byte stalls unless the output buffer is
// empty or its final word leaves in that cycle. the lfsr update is one constant gf multiply
// and xor. the last byte loads 2*CORRECTABLE_ERRORS parity symbols (or one error word) into
// the buffer, which drains one word per cycle while out_stall is low, highest index first.
// synchronous reset clears the lfsr and the byte count and empties the buffer.
module reed_solomon_255_247_encoder_core #(
  parameter int CORRECTABLE_ERRORS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_parity_byte,
  output logic [2:0] out_parity_position,
  output logic       out_status,
  output logic       out_last_result
);

  localparam int NPAR = 2 * CORRECTABLE_ERRORS;
  localparam int CNT_W = $clog2(NPAR + 1);
  localparam logic [7:0] MSG_MAX = 8'(rs_enc_pkg::CODE_LEN - NPAR);
  localparam logic [7:0] CNT_SAT = 8'(rs_enc_pkg::CODE_LEN - NPAR + 1);
  localparam rs_enc_pkg::genpoly_t GEN = rs_enc_pkg::gen_poly(NPAR);

  logic [NPAR-1:0][7:0] par_r;
  logic [NPAR-1:0][7:0] par_nxt;
  logic [NPAR-1:0][7:0] obuf_r;
  logic [7:0]           byte_cnt_r;
  logic [7:0]           byte_cnt_nxt;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_err_r;
  logic [7:0]           fb;
  logic                 too_long;
  logic                 in_acc;
  logic                 out_acc;
  logic                 load;
  logic                 buf_free;

  always_comb begin
    fb = in_data_byte ^ par_r[NPAR-1];
    par_nxt[0] = rs_enc_pkg::gf_mul(GEN[0], fb);
    for (int j = 1; j < NPAR; j++) begin
      par_nxt[j] = par_r[j-1] ^ rs_enc_pkg::gf_mul(GEN[j], fb);
    end
    byte_cnt_nxt = (byte_cnt_r < CNT_SAT) ? byte_cnt_r + 8'd1 : byte_cnt_r;
    too_long = byte_cnt_nxt > MSG_MAX;
  end

  assign out_valid = out_cnt_r != '0;
  assign out_acc   = out_valid && !out_stall;
  assign buf_free  = (out_cnt_r == '0) || ((out_cnt_r == CNT_W'(1)) && !out_stall);
  assign in_stall  = in_last_byte && !buf_free;
  assign in_acc    = in_valid && !in_stall;
  assign load      = in_acc && in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r      <= '0;
      byte_cnt_r <= '0;
      out_cnt_r  <= '0;
      out_err_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_last_byte) begin
          par_r      <= '0;
          byte_cnt_r <= '0;
        end else begin
          par_r      <= par_nxt;
          byte_cnt_r <= byte_cnt_nxt;
        end
      end
      if (load) begin
        out_cnt_r <= too_long ? CNT_W'(1) : CNT_W'(NPAR);
        out_err_r <= too_long;
      end else if (out_acc) begin
        out_cnt_r <= out_cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf_r <= too_long ? '0 : par_nxt;
    end else if (out_acc) begin
      obuf_r <= obuf_r << 8;
    end
  end

  assign out_parity_byte     = obuf_r[NPAR-1];
  assign out_parity_position = 3'(out_cnt_r - CNT_W'(1));
  assign out_status          = out_err_r;
  assign out_last_result     = out_cnt_r == CNT_W'(1);

endmodule

// ----- rtl/rs_enc_chk.sv -----
// rs_enc_chk: port-level checks for the rs encoder core, bound to the encoder core module
// depends on reed_solomon_255_247_encoder_core port names
module rs_enc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_parity_byte,
  input logic [2:0] out_parity_position,
  input logic       out_status,
  input logic       out_last_result
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_parity_byte)
      && $stable(out_parity_position) && $stable(out_status) && $stable(out_last_result))
    else $error("stalled output word changed");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_parity_byte == 8'd0 && out_parity_position == 3'd0
      && out_last_result)
    else $error("error word malformed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> out_parity_position == 3'd0)
    else $error("final word not at position zero");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_result |=> out_valid
      && out_parity_position == $past(out_parity_position) - 3'd1)
    else $error("parity positions not consecutive");

  a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_last_byte |-> !in_stall)
    else $error("inner message byte stalled");

endmodule

bind reed_solomon_255_247_encoder_core rs_enc_chk u_rs_enc_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_last_byte        (in_last_byte),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_parity_byte     (out_parity_byte),
  .out_parity_position (out_parity_position),
  .out_status          (out_status),
  .out_last_result     (out_last_result)
);

// ----- tb/testbench.sv -----
// testbench for reed_solomon_255_247_encoder_core: directed byte table, then random messages
// parity words are checked against a gf(2^8) lfsr predictor kept in this file
// depends on rs_enc_pkg and rtl/reed_solomon_255_247_encoder_core.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORR_ERRORS = 4;
  localparam int NPAR = 2 * CORR_ERRORS;
  localparam int MSG_MAX = rs_enc_pkg::CODE_LEN - NPAR;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 340;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  typedef struct packed {
    logic [7:0] parity;
    logic [2:0] position;
    logic       status;
    logic       last;
  } parity_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       zero_parity;
  } byte_row_t;

  localparam int DIRECTED_ROWS = 20;

  // zero_parity marks a message whose parity is all zero
  byte_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{8'h00, 1'b1, 1'b1},
    '{8'hFF, 1'b1, 1'b0},
    '{8'h01, 1'b1, 1'b0},
    '{8'h80, 1'b0, 1'b0},
    '{8'h7F, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0},
    '{8'h5A, 1'b1, 1'b0},
    '{8'h5A, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1},
    '{8'hAA, 1'b0, 1'b0},
    '{8'h55, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0},
    '{8'h01, 1'b0, 1'b0},
    '{8'h02, 1'b0, 1'b0},
    '{8'h04, 1'b0, 1'b0},
    '{8'h08, 1'b0, 1'b0},
    '{8'h10, 1'b1, 1'b0}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_parity_byte;
  logic [2:0] out_parity_position;
  logic       out_status;
  logic       out_last_result;

  reed_solomon_255_247_encoder_core #(
    .CORRECTABLE_ERRORS(CORR_ERRORS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_parity_byte    (out_parity_byte),
    .out_parity_position(out_parity_position),
    .out_status         (out_status),
    .out_last_result    (out_last_result)
  );

  rs_enc_pkg::sym_t gen_coef [0:NPAR];
  rs_enc_pkg::sym_t parity_lfsr [0:NPAR-1];
  int               msg_bytes;
  parity_word_t     parity_words_due [$];
  int               fail_count = 0;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               stall_mode = 0;
  int               stall_phase_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // msb-first shift and add, reduced by 0x11d
  function automatic rs_enc_pkg::sym_t gf_times(input rs_enc_pkg::sym_t a,
                                                input rs_enc_pkg::sym_t b);
    rs_enc_pkg::sym_t acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1D : 8'h00);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  task automatic build_generator();
    rs_enc_pkg::sym_t root;
    root = 8'h01;
    for (int k = 0; k <= NPAR; k++) begin
      gen_coef[k] = 8'h00;
    end
    gen_coef[0] = 8'h01;
    for (int i = 0; i < NPAR; i++) begin
      root = gf_times(root, 8'h02);
      for (int j = i + 1; j > 0; j--) begin
        gen_coef[j] = gen_coef[j-1] ^ gf_times(gen_coef[j], root);
      end
      gen_coef[0] = gf_times(gen_coef[0], root);
    end
  endtask

  task automatic clear_encoder();
    for (int j = 0; j < NPAR; j++) begin
      parity_lfsr[j] = 8'h00;
    end
    msg_bytes = 0;
  endtask

  task automatic predict_byte(input rs_enc_pkg::sym_t data, input logic last,
                              input logic zero_parity);
    rs_enc_pkg::sym_t fb;
    parity_word_t     w;
    if (msg_bytes < MSG_MAX + 1) begin
      msg_bytes++;
    end
    fb = data ^ parity_lfsr[NPAR-1];
    for (int j = NPAR - 1; j > 0; j--) begin
      parity_lfsr[j] = parity_lfsr[j-1] ^ gf_times(gen_coef[j], fb);
    end
    parity_lfsr[0] = gf_times(gen_coef[0], fb);
    if (last) begin
      if (msg_bytes > MSG_MAX) begin
        w.parity = 8'h00;
        w.position = 3'd0;
        w.status = STATUS_TOO_LONG;
        w.last = 1'b1;
        parity_words_due.push_back(w);
      end else begin
        for (int j = NPAR - 1; j >= 0; j--) begin
          w.parity = zero_parity ? 8'h00 : parity_lfsr[j];
          w.position = 3'(j);
          w.status = STATUS_OK;
          w.last = (j == 0);
          parity_words_due.push_back(w);
        end
      end
      clear_encoder();
    end
  endtask

  // sender in bursts with random gaps
  task automatic send_byte(input rs_enc_pkg::sym_t data, input logic last,
                           input logic zero_parity);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    predict_byte(data, last, zero_parity);
    burst_left--;
  endtask

  task automatic send_message(input int len, input int style);
    rs_enc_pkg::sym_t data;
    int               zeros;
    zeros = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: data = (i < zeros) ? 8'h00 : rs_enc_pkg::sym_t'($urandom_range(0, 255));
        1: data = 8'hFF;
        2: data = 8'h00;
        default: data = rs_enc_pkg::sym_t'($urandom_range(0, 255));
      endcase
      send_byte(data, i == len - 1, 1'b0);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase_left <= $urandom_range(20, 80);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    parity_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (parity_words_due.size() == 0) begin
        $error("parity word with nothing expected: byte %0h position %0d status %0b",
               out_parity_byte, out_parity_position, out_status);
        fail_count++;
      end else begin
        w = parity_words_due.pop_front();
        if (out_parity_byte !== w.parity) begin
          $error("parity_byte expected %0h got %0h", w.parity, out_parity_byte);
          fail_count++;
        end
        if (out_parity_position !== w.position) begin
          $error("parity_position expected %0d got %0d", w.position, out_parity_position);
          fail_count++;
        end
        if (out_status !== w.status) begin
          $error("status expected %0b got %0b", w.status, out_status);
          fail_count++;
        end
        if (out_last_result !== w.last) begin
          $error("last_result expected %0b got %0b", w.last, out_last_result);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word accepted on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int random_items;
    int msg_index;
    int len;
    int style;
    build_generator();
    clear_encoder();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_byte(directed_rows[r].data, directed_rows[r].last, directed_rows[r].zero_parity);
    end

    random_items = 0;
    msg_index = 0;
    while (random_items < RANDOM_ITEMS) begin
      style = $urandom_range(0, 9);
      case (msg_index)
        // one byte past the longest message
        3: begin
          send_message(MSG_MAX + 1, 3);
          random_items += MSG_MAX + 1;
        end
        default: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
          send_message(len, style);
          random_items += len;
        end
      endcase
      msg_index++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (parity_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- reed_solomon_255_247_encoder_core.f -----
rtl/rs_enc_pkg.sv
rtl/reed_solomon_255_247_encoder_core.sv
rtl/rs_enc_chk.sv
tb/testbench.sv
